// ===== rtl/core/usd_pkg.sv =====
// Shared types, constants and lead-byte decode for the UTF-8 stream decoder.
`default_nettype none

package usd_pkg;

   localparam int CP_W    = 31;
   localparam int LEN_W   = 3;
   localparam int INIT_W  = 5;
   localparam int QDEPTH  = 4;
   localparam int QPTR_W  = $clog2(QDEPTH);
   localparam int QCNT_W  = $clog2(QDEPTH + 1);

   localparam logic [1:0] ST_VALID = 2'd0;
   localparam logic [1:0] ST_STRAY = 2'd1;
   localparam logic [1:0] ST_TRUNC = 2'd2;

   localparam logic [1:0] LEAD_ASCII = 2'd0;
   localparam logic [1:0] LEAD_STRAY = 2'd1;
   localparam logic [1:0] LEAD_MULTI = 2'd2;

   typedef struct packed {
      logic [CP_W-1:0]  code_point;
      logic [1:0]       status;
      logic [LEN_W-1:0] bytes_taken;
   } result_type;

   // One queue entry holds every result caused by one byte.
   typedef struct packed {
      logic       two;
      result_type r0;
      result_type r1;
   } entry_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [LEN_W-1:0]  len;
      logic [INIT_W-1:0] init;
   } lead_type;

   function automatic result_type make_res(input logic [CP_W-1:0] cp,
                                           input logic [1:0] st,
                                           input logic [LEN_W-1:0] taken);
      result_type r;
      r.code_point  = cp;
      r.status      = st;
      r.bytes_taken = taken;
      return r;
   endfunction

   function automatic lead_type lead_decode(input logic [7:0] b);
      lead_type l;
      l.kind = LEAD_MULTI;
      l.len  = '0;
      l.init = '0;
      if (!b[7]) begin
         l.kind = LEAD_ASCII;
      end else if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
         l.kind = LEAD_STRAY;
      end else if (b[7:5] == 3'b110) begin
         l.len  = 3'd2;
         l.init = b[4:0];
      end else if (b[7:4] == 4'b1110) begin
         l.len  = 3'd3;
         l.init = {1'b0, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         l.len  = 3'd4;
         l.init = {2'b0, b[2:0]};
      end else if (b[7:2] == 6'b111110) begin
         l.len  = 3'd5;
         l.init = {3'b0, b[1:0]};
      end else begin
         l.len  = 3'd6;
         l.init = {4'b0, b[0]};
      end
      return l;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/usd_ifs.sv =====
// Valid/ready channel interfaces for the byte input and the result output.
`default_nettype none

interface usd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] text_byte;
   logic       end_of_text;

   modport source (output valid, output text_byte, output end_of_text, input ready);
   modport sink   (input valid, input text_byte, input end_of_text, output ready);
endinterface

interface usd_rsp_if;
   logic        valid;
   logic        ready;
   logic [30:0] code_point;
   logic [1:0]  status;
   logic [2:0]  bytes_taken;
   logic        last_of_run;

   modport source (output valid, output code_point, output status, output bytes_taken,
                   output last_of_run, input ready);
   modport sink   (input valid, input code_point, input status, input bytes_taken,
                   input last_of_run, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/usd_front.sv =====
// Front end: accepts bytes, tracks the pending sequence, builds result entries.
`default_nettype none

module usd_front
   import usd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   usd_req_if.sink    req_bus,
   input  wire logic  q_full,
   output logic       push,
   output entry_type  push_entry
);

   logic [CP_W-1:0]  partial_ff, partial_in;
   logic [LEN_W-1:0] exp_ff, exp_in;
   logic [LEN_W-1:0] seen_ff, seen_in;

   logic             accept;
   logic [7:0]       b;
   logic             eot;
   logic             pending;
   logic             is_cont;
   logic [LEN_W-1:0] seen_inc;
   logic [CP_W-1:0]  acc;
   lead_type         lead;
   logic             lead_has;
   result_type       lead_res;

   assign req_bus.ready = !q_full && !reset;
   assign accept   = req_bus.valid && req_bus.ready;
   assign b        = req_bus.text_byte;
   assign eot      = req_bus.end_of_text;
   assign pending  = (exp_ff != '0);
   assign is_cont  = (b[7:6] == 2'b10);
   assign seen_inc = seen_ff + 3'd1;
   assign acc      = {partial_ff[CP_W-7:0], b[5:0]};
   assign lead     = lead_decode(b);

   always_comb begin
      partial_in = partial_ff;
      exp_in     = exp_ff;
      seen_in    = seen_ff;
      push       = 1'b0;
      push_entry = '0;
      lead_has   = 1'b0;
      lead_res   = '0;

      if (pending && is_cont) begin
         if (seen_inc >= exp_ff) begin
            push          = 1'b1;
            push_entry.r0 = make_res(acc, ST_VALID, exp_ff);
            partial_in    = '0;
            exp_in        = '0;
            seen_in       = '0;
         end else if (eot) begin
            push          = 1'b1;
            push_entry.r0 = make_res('0, ST_TRUNC, seen_inc);
            partial_in    = '0;
            exp_in        = '0;
            seen_in       = '0;
         end else begin
            partial_in = acc;
            seen_in    = seen_inc;
         end
      end else begin
         // Byte taken as a lead, possibly after ending an interrupted sequence.
         partial_in = '0;
         exp_in     = '0;
         seen_in    = '0;
         case (lead.kind)
            LEAD_ASCII: begin
               lead_has = 1'b1;
               lead_res = make_res({{(CP_W-8){1'b0}}, b}, ST_VALID, 3'd1);
            end
            LEAD_STRAY: begin
               lead_has = 1'b1;
               lead_res = make_res('0, ST_STRAY, 3'd1);
            end
            default: begin
               if (eot) begin
                  lead_has = 1'b1;
                  lead_res = make_res('0, ST_TRUNC, 3'd1);
               end else begin
                  partial_in = {{(CP_W-INIT_W){1'b0}}, lead.init};
                  exp_in     = lead.len;
                  seen_in    = 3'd1;
               end
            end
         endcase
         if (pending) begin
            push           = 1'b1;
            push_entry.two = lead_has;
            push_entry.r0  = make_res('0, ST_TRUNC, seen_ff);
            push_entry.r1  = lead_res;
         end else begin
            push          = lead_has;
            push_entry.r0 = lead_res;
         end
      end

      if (!accept) begin
         push = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         partial_ff <= '0;
         exp_ff     <= '0;
         seen_ff    <= '0;
      end else if (accept) begin
         partial_ff <= partial_in;
         exp_ff     <= exp_in;
         seen_ff    <= seen_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/core/usd_queue.sv =====
// Small entry queue between the front end and the result sequencer.
`default_nettype none

module usd_queue
   import usd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       push,
   input  wire entry_type  push_entry,
   output logic            full,
   input  wire logic       pop,
   output logic            head_valid,
   output entry_type       head_entry
);

   entry_type           mem_ff [QDEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full       = (count_ff == QCNT_W'(QDEPTH));
   assign head_valid = (count_ff != '0);
   assign head_entry = mem_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QDEPTH))
      else $error("queue count past depth");

   a_no_push_full: assert property (@(posedge clock) disable iff (reset)
      push |-> !full)
      else $error("push into full queue");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> head_valid)
      else $error("pop from empty queue");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (wr_ptr_ff - rd_ptr_ff) == count_ff[QPTR_W-1:0])
      else $error("queue pointers disagree with count");

endmodule

`default_nettype wire

// ===== rtl/core/usd_back.sv =====
// Back end: splits queue entries into single results behind an output register.
`default_nettype none

module usd_back
   import usd_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       head_valid,
   input  wire entry_type  head_entry,
   output logic            pop,
   usd_rsp_if.source       rsp_bus
);

   logic       sub_ff;
   logic       rsp_valid_ff;
   result_type rsp_res_ff, rsp_res_in;
   logic       rsp_last_ff, rsp_last_in;
   logic       load;

   assign load = head_valid && (!rsp_valid_ff || rsp_bus.ready);
   assign pop  = load && (!head_entry.two || sub_ff);

   always_comb begin
      rsp_res_in  = sub_ff ? head_entry.r1 : head_entry.r0;
      rsp_last_in = !head_entry.two || sub_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sub_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            rsp_valid_ff <= 1'b1;
            sub_ff       <= head_entry.two && !sub_ff;
         end else if (rsp_bus.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_res_ff  <= rsp_res_in;
         rsp_last_ff <= rsp_last_in;
      end
   end

   assign rsp_bus.valid       = rsp_valid_ff;
   assign rsp_bus.code_point  = rsp_res_ff.code_point;
   assign rsp_bus.status      = rsp_res_ff.status;
   assign rsp_bus.bytes_taken = rsp_res_ff.bytes_taken;
   assign rsp_bus.last_of_run = rsp_last_ff;

   // second half of a two-result entry must still be at the queue head
   a_sub_has_head: assert property (@(posedge clock) disable iff (reset)
      sub_ff |-> head_valid && head_entry.two)
      else $error("second result without its entry");

   a_first_not_last: assert property (@(posedge clock) disable iff (reset)
      load && head_entry.two && !sub_ff |=> !rsp_last_ff)
      else $error("first of two results marked last");

endmodule

`default_nettype wire

// ===== rtl/core/utf8_stream_decoder.sv =====
// Top level of the UTF-8 stream decoder.
//
// req_bus carries one text byte per transaction plus end_of_text, which marks
// the final byte and flushes any pending sequence as truncated. rsp_bus
// carries one result per transaction: code_point, status (valid, stray,
// truncated), bytes_taken and last_of_run on the final result of a byte.
// A byte gives zero, one or two results.
// Throughput: one byte per cycle into the front end unless the queue is full;
// the result side emits one result per cycle while the receiver is ready.
// Each result is written to the queue when its byte is accepted, then loaded
// into the output register once that register is empty or being taken.
// A four-entry queue sits between decode and output; outside reset,
// req_bus.ready drops only when that queue is full, so a stalled receiver
// backs up through the queue before the input stalls. The output register
// holds its result until taken.
// Reset clears the decode state, the queue and the output register; the
// block accepts bytes as soon as reset falls.
`default_nettype none

module utf8_stream_decoder
   import usd_pkg::*;
(
   input  wire logic  clock,
   input  wire logic  reset,
   usd_req_if.sink    req_bus,
   usd_rsp_if.source  rsp_bus
);

   logic      q_full;
   logic      push;
   entry_type push_entry;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   usd_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req_bus    (req_bus),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   usd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   usd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_bus    (rsp_bus)
   );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the UTF-8 stream decoder: byte driver, monitor, scoreboard.
module tb
   import usd_pkg::*;
();

   // One decoded result as it should appear on the result channel.
   typedef struct packed {
      logic [CP_W-1:0]  cp;
      logic [1:0]       st;
      logic [LEN_W-1:0] taken;
      logic             last;
   } decoded_type;

   typedef struct packed {
      logic [7:0] b;
      logic       eot;
   } text_item_type;

   logic clock;
   logic reset;

   usd_req_if req_bus ();
   usd_rsp_if rsp_bus ();

   utf8_stream_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus)
   );

   text_item_type pending_bytes[$];
   decoded_type   expected_chars[$];

   // Decoder state mirror
   logic [CP_W-1:0]  dec_partial;
   logic [LEN_W-1:0] dec_len;
   logic [LEN_W-1:0] dec_seen;

   int bytes_queued;
   int bytes_accepted;
   int results_seen;
   int mismatches;
   int n_valid, n_stray, n_trunc, n_double;
   int req_gap, req_burst, rsp_gap, rsp_burst;
   bit req_fired, rsp_fired, rsp_hold, random_phase;

   function automatic int pick_gap(inout int burst);
      int r;
      if (burst > 0) begin
         burst--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 4) begin
         burst = $urandom_range(20, 60);
         return 0;
      end
      if (r < 55) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 50);
   endfunction

   function automatic void clear_sequence();
      dec_partial = '0;
      dec_len     = '0;
      dec_seen    = '0;
   endfunction

   // Decode b as a lead byte with nothing pending; 1 when it gives a result.
   function automatic int lead_result(input logic [7:0] b, output decoded_type r);
      r = '0;
      if (!b[7]) begin
         r = {{(CP_W-8){1'b0}}, b, ST_VALID, 3'd1, 1'b0};
         return 1;
      end
      if (b[7:6] == 2'b10 || b[7:1] == 7'h7F) begin
         r = {{CP_W{1'b0}}, ST_STRAY, 3'd1, 1'b0};
         return 1;
      end
      if (b[7:5] == 3'b110) begin
         dec_len = 3'd2; dec_partial = {{(CP_W-5){1'b0}}, b[4:0]};
      end else if (b[7:4] == 4'b1110) begin
         dec_len = 3'd3; dec_partial = {{(CP_W-4){1'b0}}, b[3:0]};
      end else if (b[7:3] == 5'b11110) begin
         dec_len = 3'd4; dec_partial = {{(CP_W-3){1'b0}}, b[2:0]};
      end else if (b[7:2] == 6'b111110) begin
         dec_len = 3'd5; dec_partial = {{(CP_W-2){1'b0}}, b[1:0]};
      end else begin
         dec_len = 3'd6; dec_partial = {{(CP_W-1){1'b0}}, b[0]};
      end
      dec_seen = 3'd1;
      return 0;
   endfunction

   function automatic void predict_decode(input logic [7:0] b, input logic eot);
      decoded_type r[2];
      decoded_type one;
      int n;
      n = 0;
      if (dec_len != 0) begin
         if (b[7:6] == 2'b10) begin
            dec_partial = {dec_partial[CP_W-7:0], b[5:0]};
            dec_seen    = dec_seen + 3'd1;
            if (dec_seen >= dec_len) begin
               r[0] = {dec_partial, ST_VALID, dec_len, 1'b0};
               n = 1;
               clear_sequence();
            end
         end else begin
            // interrupted: flush the pending sequence, then retry b as a lead
            r[0] = {{CP_W{1'b0}}, ST_TRUNC, dec_seen, 1'b0};
            n = 1;
            clear_sequence();
            if (lead_result(b, one) != 0) begin
               r[1] = one;
               n = 2;
            end
         end
      end else if (lead_result(b, one) != 0) begin
         r[0] = one;
         n = 1;
      end
      if (eot && dec_len != 0) begin
         r[n] = {{CP_W{1'b0}}, ST_TRUNC, dec_seen, 1'b0};
         n++;
         clear_sequence();
      end
      if (n > 0) r[n-1].last = 1'b1;
      for (int i = 0; i < n; i++) expected_chars.push_back(r[i]);
   endfunction

   task automatic report_field(input string name, input logic [30:0] want,
                               input logic [30:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
         mismatches++;
      end
   endtask

   task automatic push_byte(input logic [7:0] b, input logic eot);
      text_item_type t;
      t.b   = b;
      t.eot = eot;
      pending_bytes.push_back(t);
      bytes_queued++;
   endtask

   // One character, a cut-short sequence, or a noise byte.
   task automatic random_unit(output int n);
      int kind, w, len, keep;
      logic [7:0] b;
      logic [7:0] c;
      kind = $urandom_range(0, 99);
      n = 0;
      if (kind < 10) begin
         push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 39) == 0);
         n = 1;
         return;
      end
      w = $urandom_range(0, 99);
      if (w < 30)      len = 1;
      else if (w < 50) len = 2;
      else if (w < 70) len = 3;
      else if (w < 85) len = 4;
      else if (w < 93) len = 5;
      else             len = 6;
      keep = len;
      if (kind < 25 && len > 1) keep = $urandom_range(1, len - 1);
      b = 8'($urandom);
      case (len)
         1: b[7]   = 1'b0;
         2: b[7:5] = 3'b110;
         3: b[7:4] = 4'b1110;
         4: b[7:3] = 5'b11110;
         5: b[7:2] = 6'b111110;
         default: b[7:1] = 7'b1111110;
      endcase
      push_byte(b, $urandom_range(0, 39) == 0);
      n = 1;
      for (int i = 1; i < keep; i++) begin
         c = 8'($urandom);
         c[7:6] = 2'b10;
         push_byte(c, $urandom_range(0, 39) == 0);
         n++;
      end
   endtask

   task automatic wait_drained();
      while (bytes_accepted != bytes_queued || expected_chars.size() != 0)
         @(negedge clock);
   endtask

   initial begin
      clock = 1'b0;
      reset = 1'b1;
      req_bus.valid       = 1'b0;
      req_bus.text_byte   = 8'h00;
      req_bus.end_of_text = 1'b0;
      rsp_bus.ready       = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   initial begin
      #(20 * 1000000);
      $display("FAIL utf8_stream_decoder");
      $finish;
   end

   // Receiver holds off for a long stretch while the sender keeps offering.
   initial begin
      wait (random_phase);
      repeat (30) @(posedge clock);
      rsp_hold = 1'b1;
      repeat (120) @(posedge clock);
      rsp_hold = 1'b0;
   end

   initial begin
      int total, n;
      wait (reset == 1'b0);
      // extremes, strays, full-length sequences
      push_byte(8'h00, 0); push_byte(8'h7F, 0); push_byte(8'h80, 0);
      push_byte(8'hFF, 0); push_byte(8'hFE, 0);
      push_byte(8'hC2, 0); push_byte(8'hA9, 0);
      push_byte(8'hE2, 0); push_byte(8'h82, 0); push_byte(8'hAC, 0);
      push_byte(8'hFD, 0);
      repeat (5) push_byte(8'hBF, 0);
      // interruptions: by ASCII, by a new lead, by an invalid byte
      push_byte(8'hC3, 0); push_byte(8'h41, 0);
      push_byte(8'hF0, 0); push_byte(8'hF8, 0); push_byte(8'hFE, 0);
      // end-of-text flushes, one of them after an interruption
      push_byte(8'hDF, 1);
      push_byte(8'hE0, 0); push_byte(8'h80, 0); push_byte(8'hC0, 1);
      wait_drained();

      random_phase = 1'b1;
      for (int batch = 0; batch < 4; batch++) begin
         total = 0;
         while (total < 363) begin
            random_unit(n);
            total += n;
         end
         wait_drained();
      end
      repeat (8) @(posedge clock);

      $display("Decoded %0d bytes into %0d results: %0d valid, %0d stray, %0d truncated",
               bytes_accepted, results_seen, n_valid, n_stray, n_trunc);
      $display("%0d bytes gave two results; lengths 1 to 6, cut-short runs and flushes seen",
               n_double);
      if (mismatches == 0 && expected_chars.size() == 0) begin
         $display("PASS utf8_stream_decoder");
      end else begin
         $display("FAIL utf8_stream_decoder");
      end
      $finish;
   end

   // Byte driver
   always @(negedge clock) begin
      text_item_type t;
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else if (req_bus.valid && !req_fired) begin
         // transaction still pending, hold the bus
      end else if (req_gap > 0) begin
         req_gap--;
         req_bus.valid     <= 1'b0;
         req_bus.text_byte <= 8'($urandom);
      end else if (pending_bytes.size() > 0) begin
         t = pending_bytes.pop_front();
         req_bus.valid       <= 1'b1;
         req_bus.text_byte   <= t.b;
         req_bus.end_of_text <= t.eot;
         req_gap = pick_gap(req_burst);
      end else begin
         req_bus.valid <= 1'b0;
      end
      req_fired = 1'b0;
   end

   // Result ready driver
   always @(negedge clock) begin
      if (rsp_fired) rsp_gap = pick_gap(rsp_burst);
      rsp_fired = 1'b0;
      if (reset || rsp_hold || rsp_gap > 0) begin
         rsp_bus.ready <= 1'b0;
         if (rsp_gap > 0) rsp_gap--;
      end else begin
         rsp_bus.ready <= 1'b1;
      end
   end

   // Monitor: predict on input transactions, then check output transactions
   always @(posedge clock) begin
      decoded_type want;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            predict_decode(req_bus.text_byte, req_bus.end_of_text);
            bytes_accepted++;
            req_fired = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            rsp_fired = 1'b1;
            results_seen++;
            if (expected_chars.size() == 0) begin
               $display("%0t: unexpected result, expected none, actual cp %0h status %0d",
                        $time, rsp_bus.code_point, rsp_bus.status);
               mismatches++;
            end else begin
               want = expected_chars.pop_front();
               report_field("code_point", want.cp, rsp_bus.code_point);
               report_field("status", want.st, rsp_bus.status);
               report_field("bytes_taken", want.taken, rsp_bus.bytes_taken);
               report_field("last_of_run", want.last, rsp_bus.last_of_run);
               case (want.st)
                  ST_VALID: n_valid++;
                  ST_STRAY: n_stray++;
                  default:  n_trunc++;
               endcase
               if (!want.last) n_double++;
            end
         end
      end
   end

endmodule

// ===== filelist.f =====
rtl/core/usd_pkg.sv
rtl/core/usd_ifs.sv
rtl/core/usd_front.sv
rtl/core/usd_queue.sv
rtl/core/usd_back.sv
rtl/core/utf8_stream_decoder.sv
tb/sv/tb.sv
